### design/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg: shared types and constants of the CSS stream minifier
// Character codes, byte classes and the result group passed front to back.
// ----------------------------------------------------------------------------
package csm_pkg;

   localparam int QDepth = 4;
   localparam int QAw    = $clog2(QDepth);

   localparam logic [7:0] CharSlash  = 8'h2F;
   localparam logic [7:0] CharStar   = 8'h2A;
   localparam logic [7:0] CharLBrace = 8'h7B;
   localparam logic [7:0] CharRBrace = 8'h7D;
   localparam logic [7:0] CharColon  = 8'h3A;
   localparam logic [7:0] CharSemi   = 8'h3B;
   localparam logic [7:0] CharComma  = 8'h2C;
   localparam logic [7:0] CharLParen = 8'h28;
   localparam logic [7:0] CharRParen = 8'h29;
   localparam logic [7:0] CharSpace  = 8'h20;
   localparam logic [7:0] CharDQuote = 8'h22;
   localparam logic [7:0] CharSQuote = 8'h27;

   // up to three result beats caused by one input beat, oldest in slot 0
   typedef struct packed {
      logic [1:0]      count;     // 1 to 3
      logic [2:0][7:0] bytes;
      logic            has_byte;  // low only for a bare end marker
      logic            last;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef struct packed {
      logic       in_string;
      logic [7:0] string_quote;
      logic       value_context;
      logic       in_comment;
      logic       comment_star_seen;
      logic       slash_held;
      logic       space_run_pending;
      logic       space_run_allowed;
      logic       prev_was_comma;
      logic       raw_last_was_space;
      logic       brace_space_eat;
   } scan_state_type;

   function automatic logic is_ws(input logic [7:0] b);
      return (b == CharSpace) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic logic is_alnum(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
             (b >= 8'h61 && b <= 8'h7A);
   endfunction

   function automatic logic is_structural(input logic [7:0] b);
      return (b == CharLBrace) || (b == CharColon) || (b == CharSemi) ||
             (b == CharComma) || (b == CharRBrace) || (b == CharLParen) ||
             (b == CharRParen);
   endfunction

endpackage

### design/css_stream_minifier.sv
// ----------------------------------------------------------------------------
// css_stream_minifier: streaming CSS minifier
// One stylesheet byte per input beat; minified bytes out, one per result beat.
// ----------------------------------------------------------------------------
// The scanner takes one byte per cycle whenever req_full is low and turns it
// into a group of zero to three result beats, which wait in a four-group
// queue; output gives a result beat per cycle rsp_pop is high. Input accepts
// thus run at a byte a cycle while each byte yields at most one result, and
// slow down to the output's one beat a cycle once bytes yield more. A byte
// with req_in_last gives at least one result (a bare end marker with
// rsp_out_has_byte low if nothing else) and returns the scanner to reset.
module css_stream_minifier import csm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_has_byte,
   output logic       rsp_out_last
);

   q_status_type q_status;
   entry_type    push_entry, head;
   logic         q_push, q_pop;

   assign req_full = q_status.full;

   csm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_entry     (push_entry)
   );

   csm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (head),
      .status     (q_status)
   );

   csm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .q_status         (q_status),
      .q_pop            (q_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_has_byte (rsp_out_has_byte),
      .rsp_out_last     (rsp_out_last)
   );

endmodule

### design/csm_front.sv
// ----------------------------------------------------------------------------
// csm_front: scanner of the CSS stream minifier
// Tracks comment, string and whitespace state and forms the result group of
// each accepted beat.
// ----------------------------------------------------------------------------
module csm_front import csm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  logic [7:0]   req_in_byte,
   input  logic         req_in_last,
   input  q_status_type q_status,
   output logic         q_push,
   output entry_type    q_entry
);

   scan_state_type state_ff, state_in;
   logic           accept;

   assign accept = req_push && !q_status.full;

   always_comb begin
      scan_state_type  s;
      logic [1:0]      cnt;
      logic [2:0][7:0] bytes;
      logic [7:0]      b;
      s     = state_ff;
      cnt   = 2'd0;
      bytes = '0;
      b     = req_in_byte;

      if (s.in_comment) begin
         if (s.comment_star_seen && b == CharSlash) begin
            s.in_comment        = 1'b0;
            s.comment_star_seen = 1'b0;
         end else begin
            s.comment_star_seen = (b == CharStar);
         end
      end else if (s.in_string) begin
         if (cnt != 2'd3) begin bytes[cnt] = b; cnt = cnt + 2'd1; end
         s.raw_last_was_space = (b == CharSpace);
         s.brace_space_eat    = 1'b0;
         if (b == s.string_quote) s.in_string = 1'b0;
         s.prev_was_comma = 1'b0;
      end else if (s.slash_held && b == CharStar) begin
         s.slash_held        = 1'b0;
         s.in_comment        = 1'b1;
         s.comment_star_seen = 1'b0;
         s.prev_was_comma    = 1'b0;
      end else begin
         if (s.slash_held) begin
            s.slash_held = 1'b0;
            if (cnt != 2'd3) begin bytes[cnt] = CharSlash; cnt = cnt + 2'd1; end
            s.raw_last_was_space = 1'b0;
            s.brace_space_eat    = 1'b0;
            s.prev_was_comma     = 1'b0;
         end
         if (is_ws(b)) begin
            if (!s.space_run_pending) begin
               s.space_run_pending = 1'b1;
               s.space_run_allowed = (s.value_context || s.prev_was_comma) &&
                                     !s.raw_last_was_space;
            end
            s.prev_was_comma = 1'b0;
         end else begin
            if (s.space_run_pending) begin
               s.space_run_pending = 1'b0;
               if (s.space_run_allowed && !is_structural(b)) begin
                  // space straight after '{' is eaten but still counts as written
                  if (!s.brace_space_eat && cnt != 2'd3) begin
                     bytes[cnt] = CharSpace;
                     cnt        = cnt + 2'd1;
                  end
                  s.raw_last_was_space = 1'b1;
                  s.brace_space_eat    = 1'b0;
               end
               s.space_run_allowed = 1'b0;
            end
            if (b == CharSlash) begin
               s.slash_held     = 1'b1;
               s.prev_was_comma = 1'b0;
            end else if (b == CharDQuote || b == CharSQuote) begin
               s.in_string     = 1'b1;
               s.string_quote  = b;
               s.value_context = 1'b1;
               if (cnt != 2'd3) begin bytes[cnt] = b; cnt = cnt + 2'd1; end
               s.raw_last_was_space = 1'b0;
               s.brace_space_eat    = 1'b0;
               s.prev_was_comma     = 1'b0;
            end else begin
               if (cnt != 2'd3) begin bytes[cnt] = b; cnt = cnt + 2'd1; end
               s.raw_last_was_space = 1'b0;
               s.brace_space_eat    = (b == CharLBrace);
               if (b == CharLBrace)
                  s.value_context = 1'b1;
               else if (b == CharRBrace || b == CharColon || b == CharSemi)
                  s.value_context = 1'b0;
               else if (is_alnum(b))
                  s.value_context = 1'b1;
               s.prev_was_comma = (b == CharComma);
            end
         end
      end

      q_entry.last     = req_in_last;
      q_entry.has_byte = 1'b1;
      if (req_in_last) begin
         if (s.space_run_pending && s.space_run_allowed) begin
            if (!s.brace_space_eat && cnt != 2'd3) begin
               bytes[cnt] = CharSpace;
               cnt        = cnt + 2'd1;
            end
         end
         if (s.slash_held && cnt != 2'd3) begin
            bytes[cnt] = CharSlash;
            cnt        = cnt + 2'd1;
         end
         if (cnt == 2'd0) begin
            // bare end marker
            q_entry.has_byte = 1'b0;
            cnt              = 2'd1;
         end
         s = '0;
      end

      q_entry.count = cnt;
      q_entry.bytes = bytes;
      q_push        = accept && (cnt != 2'd0);
      state_in      = accept ? s : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/csm_queue.sv
// ----------------------------------------------------------------------------
// csm_queue: result group queue
// Short FIFO of result groups between the scanner and the output side.
// ----------------------------------------------------------------------------
module csm_queue import csm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  entry_type    push_entry,
   input  logic         pop,
   output entry_type    head,
   output q_status_type status
);

   entry_type      slots_ff [QDepth];
   logic [QAw-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAw-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QAw:0]   fill_ff, fill_in;
   logic           do_push, do_pop;

   assign status.empty = (fill_ff == '0);
   assign status.full  = (fill_ff == (QAw+1)'(QDepth));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop)
         fill_in = fill_ff + 1'b1;
      else if (do_pop && !do_push)
         fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) slots_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### design/csm_back.sv
// ----------------------------------------------------------------------------
// csm_back: result serialiser
// Hands out the bytes of the head group one beat at a time.
// ----------------------------------------------------------------------------
module csm_back import csm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  entry_type    head,
   input  q_status_type q_status,
   output logic         q_pop,
   input  logic         rsp_pop,
   output logic         rsp_empty,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_out_has_byte,
   output logic         rsp_out_last
);

   logic [1:0] idx_ff, idx_in;
   logic       fire, final_slot;

   assign rsp_empty        = q_status.empty;
   assign final_slot       = (idx_ff == head.count - 2'd1);
   assign fire             = rsp_pop && !q_status.empty;
   assign q_pop            = fire && final_slot;
   assign rsp_out_byte     = head.has_byte ? head.bytes[idx_ff] : 8'h00;
   assign rsp_out_has_byte = head.has_byte;
   assign rsp_out_last     = head.last && final_slot;

   always_comb begin
      idx_in = idx_ff;
      if (fire) idx_in = final_slot ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

### bench/css_stream_minifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_stream_minifier_tb: self-checking bench for the CSS stream minifier
// Feeds short directed stylesheets, then random rule-like text with some
// noise. Every input beat taken by the block runs through a local model of
// the minifier. Result beats are checked in order against that model.
// ----------------------------------------------------------------------------
module css_stream_minifier_tb;
   import csm_pkg::*;

   localparam int CycleLimit  = 200_000;
   localparam int RandomBytes = 330;
   localparam int TailCycles  = 16;

   typedef struct packed {
      logic [7:0] data;
      logic       has_data;
      logic       fin;
   } min_beat_type;

   typedef struct packed {
      logic [7:0] data;
      logic       fin;
   } css_byte_type;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_push         = 1'b0;
   logic       req_full;
   logic [7:0] req_in_byte      = 8'h00;
   logic       req_in_last      = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop          = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_has_byte;
   logic       rsp_out_last;

   css_byte_type sheet_bytes_q[$];
   logic [7:0]   sheet_buf[$];
   min_beat_type minified_q[$];
   min_beat_type group_q[$];

   int unsigned beats_taken    = 0;
   int unsigned beats_total    = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned send_gap_pct;
   int unsigned recv_gap_pct;

   // model state of the scanner
   logic       in_quote, in_cmt, star_seen, slash_wait;
   logic [7:0] quote_char;
   logic       value_ctx, run_open, run_ok, after_comma, wrote_space, after_brace;

   css_stream_minifier u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_in_byte      (req_in_byte),
      .req_in_last      (req_in_last),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_has_byte (rsp_out_has_byte),
      .rsp_out_last     (rsp_out_last)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // idling phases: sender light / receiver heavy, then swapped, then none
   always_comb begin
      if (beats_taken * 3 < beats_total) begin
         send_gap_pct = 6;
         recv_gap_pct = 52;
      end else if (beats_taken * 3 < beats_total * 2) begin
         send_gap_pct = 52;
         recv_gap_pct = 6;
      end else begin
         send_gap_pct = 0;
         recv_gap_pct = 0;
      end
   end

   function void clear_scan();
      in_quote    = 1'b0;
      quote_char  = 8'h00;
      value_ctx   = 1'b0;
      in_cmt      = 1'b0;
      star_seen   = 1'b0;
      slash_wait  = 1'b0;
      run_open    = 1'b0;
      run_ok      = 1'b0;
      after_comma = 1'b0;
      wrote_space = 1'b0;
      after_brace = 1'b0;
   endfunction

   function void write_out(input logic [7:0] b, input logic quoted);
      group_q.push_back('{data: b, has_data: 1'b1, fin: 1'b0});
      wrote_space = (b == CharSpace);
      after_brace = !quoted && (b == CharLBrace);
   endfunction

   // a space from a whitespace run; swallowed straight after an open brace
   function void write_run_space();
      if (!after_brace)
         group_q.push_back('{data: CharSpace, has_data: 1'b1, fin: 1'b0});
      wrote_space = 1'b1;
      after_brace = 1'b0;
   endfunction

   function void minify_byte(input logic [7:0] b, input logic fin);
      group_q.delete();
      if (in_cmt) begin
         if (star_seen && b == CharSlash) begin
            in_cmt    = 1'b0;
            star_seen = 1'b0;
         end else begin
            star_seen = (b == CharStar);
         end
      end else if (in_quote) begin
         write_out(b, 1'b1);
         if (b == quote_char)
            in_quote = 1'b0;
         after_comma = 1'b0;
      end else if (slash_wait && b == CharStar) begin
         slash_wait  = 1'b0;
         in_cmt      = 1'b1;
         star_seen   = 1'b0;
         after_comma = 1'b0;
      end else begin
         if (slash_wait) begin
            slash_wait = 1'b0;
            write_out(CharSlash, 1'b0);
            after_comma = 1'b0;
         end
         if (b == CharSpace || (b >= 8'h09 && b <= 8'h0D)) begin
            if (!run_open) begin
               run_open = 1'b1;
               run_ok   = (value_ctx || after_comma) && !wrote_space;
            end
            after_comma = 1'b0;
         end else begin
            if (run_open) begin
               run_open = 1'b0;
               if (run_ok && !(b == CharLBrace || b == CharColon || b == CharSemi ||
                               b == CharComma || b == CharRBrace || b == CharLParen ||
                               b == CharRParen))
                  write_run_space();
               run_ok = 1'b0;
            end
            if (b == CharSlash) begin
               slash_wait  = 1'b1;
               after_comma = 1'b0;
            end else if (b == CharDQuote || b == CharSQuote) begin
               in_quote    = 1'b1;
               quote_char  = b;
               value_ctx   = 1'b1;
               write_out(b, 1'b0);
               after_comma = 1'b0;
            end else begin
               write_out(b, 1'b0);
               if (b == CharLBrace)
                  value_ctx = 1'b1;
               else if (b == CharRBrace || b == CharColon || b == CharSemi)
                  value_ctx = 1'b0;
               else if ((b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
                        (b >= "a" && b <= "z"))
                  value_ctx = 1'b1;
               after_comma = (b == CharComma);
            end
         end
      end
      if (fin) begin
         if (run_open && run_ok)
            write_run_space();
         if (slash_wait)
            write_out(CharSlash, 1'b0);
         if (group_q.size() == 0)
            group_q.push_back('{data: 8'h00, has_data: 1'b0, fin: 1'b0});
         group_q[group_q.size() - 1].fin = 1'b1;
         clear_scan();
      end
      foreach (group_q[i])
         minified_q.push_back(group_q[i]);
   endfunction

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         sheet_buf.push_back(s[i]);
   endtask

   // moves the collected text to the stimulus queue, end mark on its final byte
   task automatic close_sheet();
      foreach (sheet_buf[i])
         sheet_bytes_q.push_back('{data: sheet_buf[i], fin: (i == sheet_buf.size() - 1)});
      sheet_buf.delete();
   endtask

   task automatic add_piece();
      case ($urandom_range(0, 23))
         0:  add_text("body");
         1:  add_text(".nav a");
         2:  add_text("#id9");
         3:  add_text(" ");
         4:  add_text("\n\t");
         5:  add_text(" {");
         6:  add_text("{ ");
         7:  add_text("}");
         8:  add_text(" : ");
         9:  add_text(";");
         10: add_text(", ");
         11: add_text("margin: 0 auto;");
         12: add_text("font: 'a b' , 12px;");
         13: add_text("url( x.png )");
         14: add_text("/* note */");
         15: add_text("/**/");
         16: add_text("a/b");
         17: add_text("\"q{ \"");
         18: add_text("color:red }");
         19: add_text("h1,h2 {");
         20: sheet_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
         21: sheet_buf.push_back(8'($urandom_range(0, 255)));
         22: begin
            case ($urandom_range(0, 2))
               0: add_text("/*");
               1: add_text("'");
               default: add_text("*/");
            endcase
         end
         default: add_text(" / * ");
      endcase
   endtask

   // driver: one beat offered per cycle unless idling
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            minify_byte(req_in_byte, req_in_last);
            void'(sheet_bytes_q.pop_front());
            beats_taken <= beats_taken + 1;
         end
         if (sheet_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
            req_push    <= 1'b1;
            req_in_byte <= sheet_bytes_q[0].data;
            req_in_last <= sheet_bytes_q[0].fin;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // monitor: result beats checked against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (minified_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result beat: byte %h has_byte %b last %b",
                           rsp_out_byte, rsp_out_has_byte, rsp_out_last);
            end else if ({rsp_out_byte, rsp_out_has_byte, rsp_out_last} !== minified_q[0]) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch: expected byte %h has_byte %b last %b, ",
                            "got byte %h has_byte %b last %b"},
                           minified_q[0].data, minified_q[0].has_data, minified_q[0].fin,
                           rsp_out_byte, rsp_out_has_byte, rsp_out_last);
               void'(minified_q.pop_front());
            end else begin
               void'(minified_q.pop_front());
            end
         end
         rsp_pop <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("css_stream_minifier test failed");
         $finish;
      end
   end

   initial begin
      clear_scan();

      // directed sheets: byte extremes, lone whitespace (bare end marker),
      // run between words, space after a brace, comment then trailing slash,
      // comma run after a colon, quoted brace unterminated, open comment
      sheet_buf.push_back(8'h00);
      close_sheet();
      sheet_buf.push_back(8'hFF);
      close_sheet();
      add_text(" ");
      close_sheet();
      add_text("a\tb");
      close_sheet();
      add_text("{ x");
      close_sheet();
      add_text("/**/a/");
      close_sheet();
      add_text(":, y");
      close_sheet();
      add_text("'{ ");
      close_sheet();
      add_text("/*a");
      close_sheet();

      while (sheet_bytes_q.size() < RandomBytes) begin
         repeat ($urandom_range(1, 8))
            add_piece();
         close_sheet();
      end
      beats_total = sheet_bytes_q.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (sheet_bytes_q.size() != 0 || req_push)
         @(posedge clock);
      while (minified_q.size() != 0)
         @(posedge clock);
      repeat (TailCycles) @(posedge clock);

      if (mismatch_count == 0)
         $display("css_stream_minifier test passed");
      else
         $display("css_stream_minifier test failed");
      $finish;
   end

endmodule
